// File: design/tcrb_pkg.sv
// Package for the text console register bank: geometry constants, register
// address map, controller state type and controller/datapath command structs.
// No dependencies.
`timescale 1ns / 1ps

package tcrb_pkg;

    // Screen geometry and keyboard ring
    localparam int SCREEN_COLUMNS   = 80;
    localparam int SCREEN_ROWS      = 50;
    localparam int KEY_BUFFER_DEPTH = 16;
    localparam int SCREEN_DEPTH     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int SCR_ADDR_W       = $clog2(SCREEN_DEPTH);
    localparam int ROW_W            = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int KEY_PTR_W        = $clog2(KEY_BUFFER_DEPTH);
    localparam int BLIT_COUNT       = 7;
    localparam int BLIT_IDX_W       = $clog2(BLIT_COUNT);

    // Bus item layout
    localparam int DATA_W     = 8;
    localparam int S_TDATA_W  = 24;   // 1 + 8 + 8 bits, padded to 3 bytes
    localparam int M_TDATA_W  = 8;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register address map
    localparam logic [7:0] ADDR_ROW_SELECT   = 8'd0;
    localparam logic [7:0] ADDR_CURSOR_COL   = 8'd1;
    localparam logic [7:0] ADDR_CURSOR_ROW   = 8'd2;
    localparam logic [7:0] ADDR_CURSOR_STYLE = 8'd3;
    localparam logic [7:0] ADDR_KEY_RD_PTR   = 8'd4;
    localparam logic [7:0] ADDR_KEY_WR_PTR   = 8'd5;
    localparam logic [7:0] ADDR_KEY_DATA     = 8'd6;
    localparam logic [7:0] ADDR_BLIT_FIRST   = 8'd7;
    localparam logic [7:0] ADDR_BLIT_LAST    = 8'(7 + BLIT_COUNT - 1);
    localparam logic [7:0] WINDOW_BASE       = 8'd16;
    localparam logic [7:0] WINDOW_LAST       = 8'(16 + SCREEN_COLUMNS - 1);

    // Reset and fill values
    localparam logic [7:0] SPACE_CHAR         = 8'd32;
    localparam logic [7:0] CURSOR_STYLE_RESET = 8'd2;
    localparam logic [ROW_W-1:0] ROW_MAX      = ROW_W'(SCREEN_ROWS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEM_READ
    } tcrb_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;     // write one space into the screen this cycle
        logic exec;         // request accepted: perform its access
        logic out_load;     // load the result register
        logic out_sel_mem;  // result comes from the screen read register
    } tcrb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;   // clear pointer at the final screen entry
        logic win_read;     // pending request is a read of the screen window
    } tcrb_status_t;

endpackage

// File: design/text_console_register_bank.sv
// Top level of the text console register bank: joins controller and datapath.
// Depends on tcrb_pkg, tcrb_ctrl and tcrb_dp.
//
//   Channel  Dir  tdata bits (low to high)                 tuser/tlast
//   s_       in   operation[0] address[8:1] write_data[16:9]  none
//   m_       out  read_data[7:0]                           none
//
// Register accesses and screen writes load the result register on acceptance;
// screen window reads pass the registered screen memory read, then the result
// register. After reset the screen is filled with spaces, one entry a cycle,
// all 4000 entries (SCREEN_COLUMNS * SCREEN_ROWS); s_tready stays low meanwhile.
// One request is in flight at a time; a new one is taken while the previous
// result waits, provided that result is taken in the same cycle.
`timescale 1ns / 1ps

module text_console_register_bank import tcrb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // operation, address, write_data, 7 pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // read_data
);

    tcrb_cmd_t    cmd;
    tcrb_status_t status;

    tcrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcrb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

    // No request is taken while the screen is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !s_tready)
        else $error("request accepted during screen clear");

    // A screen read delivers its memory data on the following cycle
    a_win_read_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && status.win_read) |=> (cmd.out_load && cmd.out_sel_mem))
        else $error("screen read result not loaded one cycle later");

    // A register access or write presents its result on the next cycle
    a_reg_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !status.win_read) |=> m_tvalid)
        else $error("register access result missing");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.out_load && m_tvalid && !m_tready))
        else $error("result register overwritten before taken");

endmodule

// File: design/tcrb_ctrl.sv
// Controller for the text console register bank: screen clear sequencing,
// request acceptance and result-register valid tracking.
// Depends on tcrb_pkg.
`timescale 1ns / 1ps

module tcrb_ctrl import tcrb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  tcrb_status_t status,
    output tcrb_cmd_t    cmd
);

    tcrb_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // take a request once the result register is free next cycle
                s_tready = !out_valid_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    cmd.exec = 1'b1;
                    if (status.win_read) begin
                        state_next = ST_MEM_READ;
                    end else begin
                        cmd.out_load = 1'b1;
                    end
                end
            end
            ST_MEM_READ: begin
                cmd.out_load    = 1'b1;
                cmd.out_sel_mem = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Result valid: set on load, dropped when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// File: design/tcrb_dp.sv
// Datapath for the text console register bank: request decode, register file,
// keyboard buffer, screen memory with clear pointer, and result register.
// Depends on tcrb_pkg.
`timescale 1ns / 1ps

module tcrb_dp import tcrb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  tcrb_cmd_t            cmd,
    output tcrb_status_t         status,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Request fields
    logic              op;
    logic [7:0]        addr;
    logic [DATA_W-1:0] wdata;

    assign op    = s_tdata[0];
    assign addr  = s_tdata[8:1];
    assign wdata = s_tdata[16:9];

    // Architectural registers
    logic [ROW_W-1:0]     row_sel_reg;
    logic [DATA_W-1:0]    cur_col_reg;
    logic [DATA_W-1:0]    cur_row_reg;
    logic [DATA_W-1:0]    cur_style_reg;
    logic [KEY_PTR_W-1:0] key_rd_ptr_reg;
    logic [KEY_PTR_W-1:0] key_wr_ptr_reg;
    logic [DATA_W-1:0]    key_buf_reg [KEY_BUFFER_DEPTH];
    logic [DATA_W-1:0]    blit_reg    [BLIT_COUNT];

    // Screen memory and clear pointer
    logic [DATA_W-1:0]     screen_mem [SCREEN_DEPTH];
    logic [DATA_W-1:0]     scr_rd_reg;
    logic [SCR_ADDR_W-1:0] clr_ptr_reg;
    logic [SCR_ADDR_W-1:0] scr_idx;
    logic [SCR_ADDR_W-1:0] scr_waddr;
    logic [DATA_W-1:0]     scr_wdata;
    logic                  scr_we;
    logic                  scr_re;

    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic [DATA_W-1:0]  reg_rd;
    logic               in_window;
    logic               in_blit;
    logic [BLIT_IDX_W-1:0] blit_idx;
    logic               do_write;

    // Address decode
    assign in_window = (addr >= WINDOW_BASE) && (addr <= WINDOW_LAST);
    assign in_blit   = addr inside {[ADDR_BLIT_FIRST:ADDR_BLIT_LAST]};
    assign blit_idx  = BLIT_IDX_W'(addr - ADDR_BLIT_FIRST);
    assign do_write  = cmd.exec && (op == OP_WRITE);

    // Screen entry of the selected row; small constant multiply
    assign scr_idx = SCR_ADDR_W'(int'(row_sel_reg) * SCREEN_COLUMNS
                                 + int'(addr) - int'(WINDOW_BASE));

    assign status.win_read   = in_window && (op == OP_READ);
    assign status.clear_last = (clr_ptr_reg == SCR_ADDR_W'(SCREEN_DEPTH - 1));

    // Clear pointer sweeps the screen once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
        end
    end

    // Screen memory port control
    assign scr_we    = cmd.clear_en || (do_write && in_window);
    assign scr_re    = cmd.exec && status.win_read;
    assign scr_waddr = cmd.clear_en ? clr_ptr_reg : scr_idx;
    assign scr_wdata = cmd.clear_en ? SPACE_CHAR : wdata;

    // Screen memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (scr_we) begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_re) begin
            scr_rd_reg <= screen_mem[scr_idx];
        end
    end

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sel_reg    <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            cur_style_reg  <= CURSOR_STYLE_RESET;
            key_rd_ptr_reg <= '0;
            key_wr_ptr_reg <= '0;
            for (int i = 0; i < KEY_BUFFER_DEPTH; i++) begin
                key_buf_reg[i] <= '0;
            end
            for (int i = 0; i < BLIT_COUNT; i++) begin
                blit_reg[i] <= '0;
            end
        end else if (do_write) begin
            case (addr)
                ADDR_ROW_SELECT: begin
                    // clamp to the last row
                    if (wdata > DATA_W'(ROW_MAX)) begin
                        row_sel_reg <= ROW_MAX;
                    end else begin
                        row_sel_reg <= ROW_W'(wdata);
                    end
                end
                ADDR_CURSOR_COL:   cur_col_reg    <= wdata;
                ADDR_CURSOR_ROW:   cur_row_reg    <= wdata;
                ADDR_CURSOR_STYLE: cur_style_reg  <= wdata;
                ADDR_KEY_RD_PTR:   key_rd_ptr_reg <= wdata[KEY_PTR_W-1:0];
                ADDR_KEY_WR_PTR:   key_wr_ptr_reg <= wdata[KEY_PTR_W-1:0];
                ADDR_KEY_DATA:     key_buf_reg[key_rd_ptr_reg] <= wdata;
                default: begin
                    if (in_blit) begin
                        blit_reg[blit_idx] <= wdata;
                    end
                end
            endcase
        end
    end

    // Register read mux; unmapped addresses read zero
    always_comb begin
        case (addr)
            ADDR_ROW_SELECT:   reg_rd = DATA_W'(row_sel_reg);
            ADDR_CURSOR_COL:   reg_rd = cur_col_reg;
            ADDR_CURSOR_ROW:   reg_rd = cur_row_reg;
            ADDR_CURSOR_STYLE: reg_rd = cur_style_reg;
            ADDR_KEY_RD_PTR:   reg_rd = DATA_W'(key_rd_ptr_reg);
            ADDR_KEY_WR_PTR:   reg_rd = DATA_W'(key_wr_ptr_reg);
            ADDR_KEY_DATA:     reg_rd = key_buf_reg[key_rd_ptr_reg];
            default:           reg_rd = in_blit ? blit_reg[blit_idx] : '0;
        endcase
    end

    // Result register; writes return zero
    always_comb begin
        if (cmd.out_sel_mem) begin
            out_data_next = scr_rd_reg;
        end else if (op == OP_WRITE) begin
            out_data_next = '0;
        end else begin
            out_data_next = reg_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tdata = out_data_reg;

endmodule
